// File: sv/tes_pkg.sv
// shared types, widths and codes for the timer event slot scheduler
package tes_pkg;

   localparam int OP_W = 3;
   localparam int TIME_W = 32;
   localparam int EVENT_W = 4;
   localparam int UNIT_W = 2;
   localparam int CHAN_W = 3;
   localparam int COUNT_W = 5;
   localparam int TOTAL_W = 32;
   localparam int LATE_W = 16;
   localparam int CODE_W = 4;
   localparam int MAP_CHANNELS = 16;
   localparam int UNIT_STRIDE = 8;

   localparam int DEFAULT_EVENT_SLOTS = 16;
   localparam int DEFAULT_CHANNELS_PER_UNIT = 8;

   localparam logic [LATE_W-1:0] LATE_RESET = 16'd100;

   localparam logic [OP_W-1:0] OP_SCHEDULE   = 3'd0;
   localparam logic [OP_W-1:0] OP_CANCEL     = 3'd1;
   localparam logic [OP_W-1:0] OP_CANCEL_ALL = 3'd2;
   localparam logic [OP_W-1:0] OP_FIRE       = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

   localparam logic [UNIT_W-1:0] UNIT_ONE = 2'd1;
   localparam logic [UNIT_W-1:0] UNIT_TWO = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [TIME_W-1:0]  time_us;
      logic [EVENT_W-1:0] target_event;
      logic [UNIT_W-1:0]  fire_unit;
      logic [CHAN_W-1:0]  fire_channel;
      logic [TIME_W-1:0]  now_us;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [EVENT_W-1:0] result_event;
      logic [UNIT_W-1:0]  assigned_unit;
      logic [CHAN_W-1:0]  assigned_channel;
      logic               late;
      logic               is_active;
      logic [COUNT_W-1:0] active_count;
      logic [TOTAL_W-1:0] fired_count;
      logic [TOTAL_W-1:0] missed_count;
   } rsp_type;

endpackage

// File: sv/tes_if.sv
// request, response and register write channel interfaces
interface tes_req_if;
   logic valid;
   logic ready;
   tes_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tes_rsp_if;
   logic valid;
   logic ready;
   tes_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tes_csr_if;
   logic valid;
   logic ready;
   logic [tes_pkg::LATE_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/tes_inreg.sv
// input register stage holding one request word
module tes_inreg (
   input  logic             clock,
   input  logic             reset,
   tes_req_if.sink          req,
   input  logic             advance,
   output logic             item_valid,
   output tes_pkg::req_type item
);

   logic             item_valid_ff;
   tes_pkg::req_type item_ff;

   assign req.ready  = !item_valid_ff || advance;
   assign item_valid = item_valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req.ready) begin
         item_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= req.data;
      end
   end

endmodule

// File: sv/tes_engine.sv
// slot table, channel map, counters and the per-word decision logic
module tes_engine #(
   parameter int EVENT_SLOTS       = tes_pkg::DEFAULT_EVENT_SLOTS,
   parameter int CHANNELS_PER_UNIT = tes_pkg::DEFAULT_CHANNELS_PER_UNIT
) (
   input  logic             clock,
   input  logic             reset,
   tes_csr_if.sink          csr,
   input  logic             advance,
   input  tes_pkg::req_type item,
   output tes_pkg::rsp_type result
);

   localparam int SLOT_W  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int MAP     = tes_pkg::MAP_CHANNELS;
   localparam int CODE_W  = tes_pkg::CODE_W;
   localparam int EW      = tes_pkg::EVENT_W;
   localparam int TW      = tes_pkg::TIME_W;
   localparam int NW      = tes_pkg::TOTAL_W;
   localparam int CW      = tes_pkg::COUNT_W;
   localparam int LW      = tes_pkg::LATE_W;
   localparam int CHW     = tes_pkg::CHAN_W;

   logic [EVENT_SLOTS-1:0] slot_active_ff, slot_active_in;
   logic [MAP-1:0]         busy_ff, busy_in;
   logic [SLOT_W-1:0]      chan_slot_ff [MAP];
   logic [TW-1:0]          chan_time_ff [MAP];
   logic [NW-1:0]          fired_ff, fired_in;
   logic [NW-1:0]          missed_ff, missed_in;
   logic [CW-1:0]          active_ff, active_in;
   logic [LW-1:0]          late_limit_ff;

   logic                   slot_found;
   logic [SLOT_W-1:0]      free_slot;
   logic                   code_found;
   logic [CODE_W-1:0]      free_code;
   logic                   sched_ok;
   logic [EVENT_SLOTS-1:0] target_hit;
   logic                   target_in_range;
   logic                   fire_valid;
   logic [CODE_W-1:0]      fire_code;
   logic                   fire_hit;
   logic [SLOT_W-1:0]      fire_slot;
   logic [TW-1:0]          deadline;
   logic                   late_now;

   assign csr.ready = 1'b1;

   // lowest free slot and first free channel
   always_comb begin
      slot_found = 1'b0;
      free_slot  = '0;
      for (int s = EVENT_SLOTS - 1; s >= 0; s--) begin
         if (!slot_active_ff[s]) begin
            slot_found = 1'b1;
            free_slot  = SLOT_W'(s);
         end
      end
      code_found = 1'b0;
      free_code  = '0;
      for (int c = MAP - 1; c >= 0; c--) begin
         if ((c % tes_pkg::UNIT_STRIDE) < CHANNELS_PER_UNIT && !busy_ff[c]) begin
            code_found = 1'b1;
            free_code  = CODE_W'(c);
         end
      end
   end

   always_comb begin
      for (int s = 0; s < EVENT_SLOTS; s++) begin
         target_hit[s] = (32'(item.target_event) == s) && slot_active_ff[s];
      end
   end

   assign target_in_range = 32'(item.target_event) < EVENT_SLOTS;
   assign sched_ok  = (item.operation == tes_pkg::OP_SCHEDULE) && slot_found && code_found;

   assign fire_valid = (item.fire_unit == tes_pkg::UNIT_ONE || item.fire_unit == tes_pkg::UNIT_TWO)
                       && (32'(item.fire_channel) < CHANNELS_PER_UNIT);
   assign fire_code = {item.fire_unit == tes_pkg::UNIT_TWO, item.fire_channel};
   assign fire_hit  = fire_valid && busy_ff[fire_code];
   assign fire_slot = chan_slot_ff[fire_code];
   assign deadline  = chan_time_ff[fire_code] + TW'(late_limit_ff);
   assign late_now  = item.now_us > deadline;

   always_comb begin
      slot_active_in = slot_active_ff;
      busy_in        = busy_ff;
      fired_in       = fired_ff;
      missed_in      = missed_ff;
      active_in      = active_ff;
      result         = '0;
      unique case (item.operation)
         tes_pkg::OP_SCHEDULE: begin
            if (sched_ok) begin
               slot_active_in[free_slot] = 1'b1;
               busy_in[free_code]        = 1'b1;
               active_in                 = active_ff + 1'b1;
               result.ok                 = 1'b1;
               result.result_event       = EW'(free_slot);
               result.assigned_unit      = free_code[CODE_W-1] ? tes_pkg::UNIT_TWO
                                                               : tes_pkg::UNIT_ONE;
               result.assigned_channel   = free_code[CHW-1:0];
            end
         end
         tes_pkg::OP_CANCEL: begin
            if (|target_hit) begin
               slot_active_in = slot_active_ff & ~target_hit;
               for (int c = 0; c < MAP; c++) begin
                  if (busy_ff[c] && target_hit[chan_slot_ff[c]]) begin
                     busy_in[c] = 1'b0;
                  end
               end
               active_in = active_ff - 1'b1;
               result.ok = 1'b1;
            end
         end
         tes_pkg::OP_CANCEL_ALL: begin
            slot_active_in = '0;
            busy_in        = '0;
            active_in      = '0;
            result.ok      = 1'b1;
         end
         tes_pkg::OP_FIRE: begin
            if (fire_hit) begin
               fired_in = fired_ff + 1'b1;
               if (late_now) begin
                  missed_in   = missed_ff + 1'b1;
                  result.late = 1'b1;
               end
               slot_active_in[fire_slot] = 1'b0;
               busy_in[fire_code]        = 1'b0;
               active_in                 = active_ff - 1'b1;
               result.ok                 = 1'b1;
               result.result_event       = EW'(fire_slot);
            end
         end
         tes_pkg::OP_QUERY: begin
            result.ok        = target_in_range;
            result.is_active = |target_hit;
         end
         default: begin
         end
      endcase
      result.active_count = active_in;
      result.fired_count  = fired_in;
      result.missed_count = missed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_active_ff <= '0;
         busy_ff        <= '0;
         fired_ff       <= '0;
         missed_ff      <= '0;
         active_ff      <= '0;
         late_limit_ff  <= tes_pkg::LATE_RESET;
      end else begin
         if (csr.valid) begin
            late_limit_ff <= csr.data;
         end
         if (advance) begin
            slot_active_ff <= slot_active_in;
            busy_ff        <= busy_in;
            fired_ff       <= fired_in;
            missed_ff      <= missed_in;
            active_ff      <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && sched_ok) begin
         chan_slot_ff[free_code] <= free_slot;
         chan_time_ff[free_code] <= item.time_us;
      end
   end

`ifndef SYNTH
   a_active_matches_slots: assert property (@(posedge clock) disable iff (reset)
      32'(active_ff) == $countones(slot_active_ff))
      else $error("active count differs from slot table");

   a_busy_matches_slots: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == $countones(slot_active_ff))
      else $error("busy channels differ from active slots");

   a_fire_counts: assert property (@(posedge clock) disable iff (reset)
      advance && item.operation == tes_pkg::OP_FIRE && fire_hit
      |=> fired_ff == NW'($past(fired_ff) + 32'd1))
      else $error("matched fire not counted");

   a_schedule_takes: assert property (@(posedge clock) disable iff (reset)
      advance && sched_ok
      |=> busy_ff[$past(free_code)] && slot_active_ff[$past(free_slot)])
      else $error("schedule did not take slot and channel");
`endif

endmodule

// File: sv/tes_outreg.sv
// result register stage holding one response word
module tes_outreg (
   input  logic             clock,
   input  logic             reset,
   tes_rsp_if.source        rsp,
   input  logic             load,
   input  tes_pkg::rsp_type result,
   output logic             space
);

   logic             rsp_valid_ff;
   tes_pkg::rsp_type rsp_data_ff;

   assign space     = !rsp_valid_ff || rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (space) begin
         rsp_valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// File: sv/timer_event_slot_scheduler.sv
// top level of the timer event slot scheduler
//
//   channel  | dir | moves
//   req_ch   | in  | one operation word per handshake
//   rsp_ch   | out | one response word per operation
//   csr_ch   | in  | late limit write, always ready
//
// one word per cycle sustained while rsp_ready stays high; a response passes through
// the input register, one pass of table logic and the result register
// reset clears the slot table, the busy map and the totals; late limit goes to 100
// no clearing pass after reset
// with rsp_ready low the result holds and req_ready drops once the input register fills
module timer_event_slot_scheduler #(
   parameter int EVENT_SLOTS       = tes_pkg::DEFAULT_EVENT_SLOTS,
   parameter int CHANNELS_PER_UNIT = tes_pkg::DEFAULT_CHANNELS_PER_UNIT
) (
   input logic       clock,
   input logic       reset,
   tes_req_if.sink   req_ch,
   tes_rsp_if.source rsp_ch,
   tes_csr_if.sink   csr_ch
);

   logic             item_valid;
   tes_pkg::req_type item;
   tes_pkg::rsp_type result;
   logic             space;
   logic             advance;

   assign advance = item_valid && space;

   tes_inreg u_inreg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tes_engine #(
      .EVENT_SLOTS       (EVENT_SLOTS),
      .CHANNELS_PER_UNIT (CHANNELS_PER_UNIT)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_ch),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   tes_outreg u_outreg (
      .clock  (clock),
      .reset  (reset),
      .rsp    (rsp_ch),
      .load   (advance),
      .result (result),
      .space  (space)
   );

endmodule

// File: sim/timer_event_slot_scheduler_tb.sv
`timescale 1ns / 100ps
// regression testbench for the timer event slot scheduler: directed and random operations
module timer_event_slot_scheduler_tb;
   import tes_pkg::*;

   localparam int SLOTS = DEFAULT_EVENT_SLOTS;
   localparam int CH_PER_UNIT = DEFAULT_CHANNELS_PER_UNIT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int REPORT_MAX = 10;

   localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd5;
   localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd6;
   localparam logic [OP_W-1:0] OP_RESERVED_C = 3'd7;
   localparam logic [UNIT_W-1:0] UNIT_NONE = 2'd0;
   localparam logic [UNIT_W-1:0] UNIT_SPARE = 2'd3;

   logic clock;
   logic reset;

   tes_req_if req_ch ();
   tes_rsp_if rsp_ch ();
   tes_csr_if csr_ch ();

   timer_event_slot_scheduler u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // scheduler state as predicted
   bit                 slot_on    [SLOTS];
   logic [TIME_W-1:0]  slot_due   [SLOTS];
   logic [CODE_W-1:0]  slot_code  [SLOTS];
   bit                 chan_taken [MAP_CHANNELS];
   logic [TOTAL_W-1:0] fired_tally;
   logic [TOTAL_W-1:0] missed_tally;
   logic [COUNT_W-1:0] active_tally;
   logic [LATE_W-1:0]  late_limit;

   rsp_type pending_rsp[$];
   int      mismatches = 0;
   int      words_checked = 0;
   int      schedule_rejects = 0;
   int      limit_writes = 0;
   int      cycle_count = 0;
   bit      idle_on = 1'b1;
   int      rsp_hold_len = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timer_event_slot_scheduler regression: fail");
      $finish;
   end

   function automatic logic release_slot(int s);
      if (s >= SLOTS || !slot_on[s])
         return 1'b0;
      chan_taken[slot_code[s]] = 1'b0;
      slot_on[s] = 1'b0;
      active_tally = active_tally - 1'b1;
      return 1'b1;
   endfunction

   function automatic rsp_type scheduler_step(req_type w);
      rsp_type r;
      int free_slot;
      int free_code;
      int s;
      int c;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] deadline;
      r = '0;
      case (w.operation)
         OP_SCHEDULE: begin
            free_slot = -1;
            free_code = -1;
            for (s = 0; s < SLOTS; s++)
               if (!slot_on[s] && free_slot < 0)
                  free_slot = s;
            for (c = 0; c < MAP_CHANNELS; c++)
               if ((c % UNIT_STRIDE) < CH_PER_UNIT && !chan_taken[c] && free_code < 0)
                  free_code = c;
            if (free_slot >= 0 && free_code >= 0) begin
               chan_taken[free_code] = 1'b1;
               slot_on[free_slot] = 1'b1;
               slot_due[free_slot] = w.time_us;
               slot_code[free_slot] = free_code[CODE_W-1:0];
               active_tally = active_tally + 1'b1;
               r.ok = 1'b1;
               r.result_event = free_slot[EVENT_W-1:0];
               r.assigned_unit = (free_code / UNIT_STRIDE == 0) ? UNIT_ONE : UNIT_TWO;
               r.assigned_channel = CHAN_W'(free_code % UNIT_STRIDE);
            end
         end
         OP_CANCEL: r.ok = release_slot(int'(w.target_event));
         OP_CANCEL_ALL: begin
            for (s = 0; s < SLOTS; s++)
               void'(release_slot(s));
            r.ok = 1'b1;
         end
         OP_FIRE: begin
            if ((w.fire_unit == UNIT_ONE || w.fire_unit == UNIT_TWO)
                && w.fire_channel < CH_PER_UNIT) begin
               code = {w.fire_unit == UNIT_TWO, w.fire_channel};
               for (s = 0; s < SLOTS; s++) begin
                  if (!r.ok && slot_on[s] && slot_code[s] == code) begin
                     fired_tally = fired_tally + 1'b1;
                     deadline = slot_due[s] + late_limit;
                     if (w.now_us > deadline) begin
                        missed_tally = missed_tally + 1'b1;
                        r.late = 1'b1;
                     end
                     void'(release_slot(s));
                     r.ok = 1'b1;
                     r.result_event = s[EVENT_W-1:0];
                  end
               end
            end
         end
         OP_QUERY: begin
            if (w.target_event < SLOTS) begin
               r.ok = 1'b1;
               r.is_active = slot_on[w.target_event];
            end
         end
         default: ;
      endcase
      r.active_count = active_tally;
      r.fired_count = fired_tally;
      r.missed_count = missed_tally;
      return r;
   endfunction

   always @(posedge clock) begin : scoreboard
      rsp_type got;
      rsp_type want;
      string diff;
      int s;
      if (reset) begin
         for (s = 0; s < SLOTS; s++) begin
            slot_on[s] = 1'b0;
            slot_due[s] = '0;
            slot_code[s] = '0;
         end
         for (s = 0; s < MAP_CHANNELS; s++)
            chan_taken[s] = 1'b0;
         fired_tally = '0;
         missed_tally = '0;
         active_tally = '0;
         late_limit = LATE_RESET;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            words_checked++;
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("response word with nothing pending: %h", got);
            end else begin
               want = pending_rsp.pop_front();
               diff = "";
               if (got.ok !== want.ok) diff = {diff, " ok"};
               if (got.result_event !== want.result_event) diff = {diff, " result_event"};
               if (got.assigned_unit !== want.assigned_unit) diff = {diff, " assigned_unit"};
               if (got.assigned_channel !== want.assigned_channel)
                  diff = {diff, " assigned_channel"};
               if (got.late !== want.late) diff = {diff, " late"};
               if (got.is_active !== want.is_active) diff = {diff, " is_active"};
               if (got.active_count !== want.active_count) diff = {diff, " active_count"};
               if (got.fired_count !== want.fired_count) diff = {diff, " fired_count"};
               if (got.missed_count !== want.missed_count) diff = {diff, " missed_count"};
               if (diff != "") begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch in%s: expected %h, got %h", diff, want, got);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            late_limit = csr_ch.data;
         if (req_ch.valid && req_ch.ready) begin
            want = scheduler_step(req_ch.data);
            if (req_ch.data.operation == OP_SCHEDULE && !want.ok)
               schedule_rejects++;
            pending_rsp.push_back(want);
         end
      end
   end

   // response side pacing, with an on-demand long hold
   initial begin : sink_pacing
      int stall;
      forever begin
         if (rsp_hold_len != 0) begin
            stall = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 15);
         end else begin
            stall = 0;
         end
         rsp_ch.ready <= (stall == 0);
         repeat ((stall == 0) ? 1 : stall) @(posedge clock);
      end
   end

   function automatic req_type make_word(logic [OP_W-1:0] op, logic [TIME_W-1:0] due,
                                         logic [EVENT_W-1:0] slot, logic [UNIT_W-1:0] unit,
                                         logic [CHAN_W-1:0] chan, logic [TIME_W-1:0] now);
      req_type w;
      w.operation = op;
      w.time_us = due;
      w.target_event = slot;
      w.fire_unit = unit;
      w.fire_channel = chan;
      w.now_us = now;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int pick;
      int s;
      int k;
      int start;
      int off;
      w.operation = OP_QUERY;
      case ($urandom_range(0, 3))
         0: w.time_us = $urandom_range(0, 255);
         1: w.time_us = 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: w.time_us = $urandom;
      endcase
      w.target_event = EVENT_W'($urandom_range(0, 15));
      w.fire_unit = UNIT_W'($urandom_range(0, 3));
      w.fire_channel = CHAN_W'($urandom_range(0, 7));
      w.now_us = $urandom;
      s = -1;
      start = $urandom_range(0, SLOTS - 1);
      for (k = 0; k < SLOTS; k++)
         if (s < 0 && slot_on[(start + k) % SLOTS])
            s = (start + k) % SLOTS;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         w.operation = OP_SCHEDULE;
      end else if (pick < 70) begin
         w.operation = OP_FIRE;
         if (s >= 0 && pick < 64) begin
            w.fire_unit = slot_code[s][CODE_W-1] ? UNIT_TWO : UNIT_ONE;
            w.fire_channel = slot_code[s][CHAN_W-1:0];
            case ($urandom_range(0, 3))
               0: off = $urandom_range(0, 4) - 2;
               1: off = -$urandom_range(0, 70000);
               2: off = $urandom_range(0, 70000);
               default: off = $urandom;
            endcase
            w.now_us = slot_due[s] + late_limit + off;
         end
      end else if (pick < 82) begin
         w.operation = OP_CANCEL;
         if (s >= 0 && pick < 79)
            w.target_event = EVENT_W'(s);
      end else if (pick < 93) begin
         w.operation = OP_QUERY;
      end else if (pick < 96) begin
         w.operation = OP_CANCEL_ALL;
      end else begin
         case ($urandom_range(0, 2))
            0: w.operation = OP_RESERVED_A;
            1: w.operation = OP_RESERVED_B;
            default: w.operation = OP_RESERVED_C;
         endcase
      end
      return w;
   endfunction

   // returns at the edge where the word is taken, valid left high
   task automatic send_word(req_type w);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_until_settled();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_late_limit(logic [LATE_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      limit_writes++;
   endtask

   task automatic run_random(int count);
      repeat (count) send_word(random_word());
      wait_until_settled();
   endtask

   task automatic test_directed_ops();
      send_word(make_word(OP_QUERY, 0, 0, 0, 0, 0));
      send_word(make_word(OP_QUERY, 0, 15, 0, 0, 0));
      send_word(make_word(OP_FIRE, 0, 0, UNIT_ONE, 0, 0));
      send_word(make_word(OP_CANCEL, 0, 3, 0, 0, 0));
      send_word(make_word(OP_SCHEDULE, 32'd0, 0, 0, 0, 0));
      send_word(make_word(OP_SCHEDULE, 32'hFFFF_FFF0, 0, 0, 0, 0));
      send_word(make_word(OP_SCHEDULE, 32'd1000, 0, 0, 0, 0));
      send_word(make_word(OP_FIRE, 0, 0, UNIT_NONE, 0, 32'hFFFF_FFFF));
      send_word(make_word(OP_FIRE, 0, 0, UNIT_SPARE, 7, 0));
      send_word(make_word(OP_FIRE, 0, 0, UNIT_TWO, 0, 0));
      // deadline wraps past zero
      send_word(make_word(OP_FIRE, 0, 0, UNIT_ONE, 1, 32'h55));
      // exactly at the deadline is on time
      send_word(make_word(OP_FIRE, 0, 0, UNIT_ONE, 0, 32'd100));
      send_word(make_word(OP_SCHEDULE, 32'd5000, 0, 0, 0, 0));
      send_word(make_word(OP_FIRE, 0, 0, UNIT_ONE, 0, 32'd5101));
      send_word(make_word(OP_QUERY, 0, 2, 0, 0, 0));
      send_word(make_word(OP_CANCEL, 0, 2, 0, 0, 0));
      send_word(make_word(OP_CANCEL, 0, 2, 0, 0, 0));
      send_word(make_word(OP_RESERVED_A, $urandom, 15, UNIT_ONE, 7, $urandom));
      send_word(make_word(OP_RESERVED_B, $urandom, 0, UNIT_TWO, 0, $urandom));
      send_word(make_word(OP_RESERVED_C, 32'hFFFF_FFFF, 15, UNIT_SPARE, 7, 32'hFFFF_FFFF));
      send_word(make_word(OP_CANCEL_ALL, 0, 0, 0, 0, 0));
      send_word(make_word(OP_QUERY, 0, 1, 0, 0, 0));
      wait_until_settled();
   endtask

   task automatic test_table_capacity();
      repeat (SLOTS + 1) send_word(make_word(OP_SCHEDULE, $urandom, 0, 0, 0, 0));
      send_word(make_word(OP_FIRE, 0, 0, UNIT_TWO, 7, 32'hFFFF_FFFF));
      send_word(make_word(OP_QUERY, 0, 15, 0, 0, 0));
      send_word(make_word(OP_SCHEDULE, 32'hFFFF_FFFF, 0, 0, 0, 0));
      send_word(make_word(OP_CANCEL, 0, 0, 0, 0, 0));
      send_word(make_word(OP_SCHEDULE, 32'd0, 0, 0, 0, 0));
      send_word(make_word(OP_CANCEL_ALL, 0, 0, 0, 0, 0));
      wait_until_settled();
   endtask

   task automatic test_late_limit_settings();
      write_late_limit('0);
      run_random(300);
      write_late_limit({LATE_W{1'b1}});
      run_random(300);
      write_late_limit(LATE_W'($urandom_range(1, 65534)));
      run_random(400);
      write_late_limit(LATE_RESET);
      run_random(300);
   endtask

   task automatic test_output_stall();
      idle_on = 1'b0;
      rsp_hold_len = 80;
      repeat (24) send_word(random_word());
      wait_until_settled();
      idle_on = 1'b1;
   endtask

   task automatic test_full_rate();
      idle_on = 1'b0;
      run_random(400);
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_table_capacity();
      test_late_limit_settings();
      test_output_stall();
      test_full_rate();
      repeat (8) @(posedge clock);
      $display("checked %0d response words: %0d events fired, %0d of them late",
               words_checked, fired_tally, missed_tally);
      $display("%0d schedules rejected, %0d late limit writes, %0d mismatches",
               schedule_rejects, limit_writes, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("timer_event_slot_scheduler regression: pass");
      else
         $display("timer_event_slot_scheduler regression: fail");
      $finish;
   end

endmodule

// File: sim.f
sv/tes_pkg.sv
sv/tes_if.sv
sv/tes_inreg.sv
sv/tes_engine.sv
sv/tes_outreg.sv
sv/timer_event_slot_scheduler.sv
sim/timer_event_slot_scheduler_tb.sv
